// File: hdl/ptmr_pkg.sv
// Shared types and constants for the periodic multi-channel timer.
// No dependencies; used by every file of the block by scoped names.
package ptmr_pkg;

	localparam int SLOT_W = 4;
	localparam int NOW_W  = 48;
	localparam int WAIT_W = 32;

	localparam logic [WAIT_W-1:0] DEFAULT_WAIT_RST = 32'd16667;

	localparam logic [1:0] REQ_REGISTER   = 2'd0;
	localparam logic [1:0] REQ_UNREGISTER = 2'd1;
	localparam logic [1:0] REQ_TICK       = 2'd2;

	localparam logic KIND_FIRE = 1'b0;
	localparam logic KIND_WAIT = 1'b1;

	typedef logic [WAIT_W-1:0] wait_t;

	// result of evaluating one channel during a tick scan
	typedef struct packed {
		logic  fire;
		wait_t wait_nxt;
	} eval_res_t;

endpackage

// File: hdl/ptmr_ifs.sv
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on ptmr_pkg for the payload widths.
interface ptmr_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    req_type;
	logic [ptmr_pkg::SLOT_W-1:0]   slot;
	logic [ptmr_pkg::WAIT_W-1:0]   period;
	logic [ptmr_pkg::NOW_W-1:0]    now;

	modport source (output valid, req_type, slot, period, now, input ready);
	modport sink   (input valid, req_type, slot, period, now, output ready);
endinterface

interface ptmr_res_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [ptmr_pkg::SLOT_W-1:0]   fired_slot;
	logic [ptmr_pkg::WAIT_W-1:0]   next_wait;
	logic                          last;

	modport source (output valid, kind, fired_slot, next_wait, last, input ready);
	modport sink   (input valid, kind, fired_slot, next_wait, last, output ready);
endinterface

interface ptmr_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ptmr_pkg::WAIT_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// File: hdl/ptmr_chan_mem.sv
// Channel table storage: period and last-fire stamp per channel.
// One write port, one registered read port. Depends on ptmr_pkg.
module ptmr_chan_mem #(
	parameter int NUM_CHANNELS = 16,
	parameter int TIME_BITS    = 48,
	localparam int IDX_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                  clk,
	input  logic [IDX_W-1:0]      waddr,
	input  logic                  we_period,
	input  logic                  we_last,
	input  ptmr_pkg::wait_t       wperiod,
	input  logic [TIME_BITS-1:0]  wlast,
	input  logic                  re,
	input  logic [IDX_W-1:0]      raddr,
	output ptmr_pkg::wait_t       rperiod_q,
	output logic [TIME_BITS-1:0]  rlast_q
);

	ptmr_pkg::wait_t      period_mem [NUM_CHANNELS];
	logic [TIME_BITS-1:0] last_mem   [NUM_CHANNELS];

	always_ff @(posedge clk) begin
		if (we_period) begin
			period_mem[waddr] <= wperiod;
		end
		if (we_last) begin
			last_mem[waddr] <= wlast;
		end
		if (re) begin
			rperiod_q <= period_mem[raddr];
			rlast_q   <= last_mem[raddr];
		end
	end

endmodule

// File: hdl/ptmr_eval.sv
// Shared evaluation unit: elapsed time, fire decision, remaining time and
// running minimum of the wait for one channel. Depends on ptmr_pkg.
module ptmr_eval #(
	parameter int TIME_BITS = 48
) (
	input  ptmr_pkg::wait_t       period,
	input  logic [TIME_BITS-1:0]  last_fire,
	input  logic [TIME_BITS-1:0]  now,
	input  ptmr_pkg::wait_t       wait_cur,
	input  logic                  any,
	output ptmr_pkg::eval_res_t   res
);

	logic [TIME_BITS-1:0] elapsed;
	logic [TIME_BITS-1:0] period_ext;
	ptmr_pkg::wait_t      left;
	ptmr_pkg::wait_t      cand;

	always_comb begin
		elapsed    = now - last_fire;
		period_ext = TIME_BITS'(period);
		res.fire   = (elapsed >= period_ext);
		// elapsed < period here, so the low bits are enough
		left       = period - elapsed[ptmr_pkg::WAIT_W-1:0];
		// a fired channel offers its period, a waiting one its remainder
		cand       = res.fire ? period : left;
		res.wait_nxt = (!any || (cand < wait_cur)) ? cand : wait_cur;
	end

endmodule

// File: hdl/periodic_multi_channel_timer.sv
// Periodic multi-channel timer. Register and unregister are handled in idle.
// A tick scans the table in slot order: a free channel is skipped in the fetch
// state, a valid channel passes through fetch (registered table read), then
// evaluation, then the wait report is sent; a firing channel or the report
// waits while the result side stalls. Requests are not taken during a scan.
// Reset clears the valid marks and sets default_wait to 16667.
module periodic_multi_channel_timer #(
	parameter int NUM_CHANNELS = 16,
	parameter int TIME_BITS    = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	ptmr_req_if.sink    req,
	ptmr_res_if.source  res,
	ptmr_cfg_if.sink    cfg
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_FETCH  = 4'b0010,
		ST_EVAL   = 4'b0100,
		ST_REPORT = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [IDX_W-1:0]         idx_q;
	logic [NUM_CHANNELS-1:0]  chan_valid_q;
	logic [TIME_BITS-1:0]     now_q;
	ptmr_pkg::wait_t          wait_q;
	logic                     any_q;
	ptmr_pkg::wait_t          default_wait_q;

	logic                          out_valid_q;
	logic                          out_kind_q;
	logic [ptmr_pkg::SLOT_W-1:0]   out_slot_q;
	ptmr_pkg::wait_t               out_wait_q;
	logic                          out_last_q;

	logic                          req_xfer;
	logic                          out_free;
	logic                          out_load;
	logic [IDX_W+ptmr_pkg::SLOT_W-1:0]     slot_wide;
	logic [IDX_W-1:0]                      slot_idx;
	logic                                  slot_ok;
	logic [TIME_BITS+ptmr_pkg::NOW_W-1:0]  now_wide;
	logic [TIME_BITS-1:0]                  now_t;
	logic [IDX_W+ptmr_pkg::SLOT_W-1:0]     idx_wide;

	logic                  mem_we_period;
	logic                  mem_we_last;
	logic [IDX_W-1:0]      mem_waddr;
	logic [TIME_BITS-1:0]  mem_wlast;
	logic                  mem_re;
	ptmr_pkg::wait_t       rd_period_q;
	logic [TIME_BITS-1:0]  rd_last_q;

	ptmr_pkg::eval_res_t   ev;

	assign req.ready  = (state_q == ST_IDLE);
	assign req_xfer   = req.valid && req.ready;
	assign out_free   = !out_valid_q || res.ready;
	assign cfg.ready  = 1'b1;

	// output register takes a fire result or the wait report
	assign out_load   = out_free && ((state_q == ST_EVAL && ev.fire) || state_q == ST_REPORT);

	assign slot_wide  = (IDX_W + ptmr_pkg::SLOT_W)'(req.slot);
	assign slot_idx   = slot_wide[IDX_W-1:0];
	assign slot_ok    = (32'(req.slot) < NUM_CHANNELS);
	assign now_wide   = (TIME_BITS + ptmr_pkg::NOW_W)'(req.now);
	assign now_t      = now_wide[TIME_BITS-1:0];
	assign idx_wide   = (IDX_W + ptmr_pkg::SLOT_W)'(idx_q);

	assign res.valid      = out_valid_q;
	assign res.kind       = out_kind_q;
	assign res.fired_slot = out_slot_q;
	assign res.next_wait  = out_wait_q;
	assign res.last       = out_last_q;

	// table write port: register in idle, restamp during evaluation
	always_comb begin
		mem_we_period = 1'b0;
		mem_we_last   = 1'b0;
		mem_waddr     = idx_q;
		mem_wlast     = now_q;
		if (state_q == ST_IDLE) begin
			mem_waddr = slot_idx;
			mem_wlast = now_t;
			if (req_xfer && req.req_type == ptmr_pkg::REQ_REGISTER && slot_ok
			    && !chan_valid_q[slot_idx]) begin
				mem_we_period = 1'b1;
				mem_we_last   = 1'b1;
			end
		end else if (state_q == ST_EVAL && ev.fire && out_free) begin
			mem_we_last = 1'b1;
		end
	end

	assign mem_re = (state_q == ST_FETCH) && chan_valid_q[idx_q];

	ptmr_chan_mem #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.TIME_BITS    (TIME_BITS)
	) u_mem (
		.clk       (clk),
		.waddr     (mem_waddr),
		.we_period (mem_we_period),
		.we_last   (mem_we_last),
		.wperiod   (req.period),
		.wlast     (mem_wlast),
		.re        (mem_re),
		.raddr     (idx_q),
		.rperiod_q (rd_period_q),
		.rlast_q   (rd_last_q)
	);

	ptmr_eval #(
		.TIME_BITS (TIME_BITS)
	) u_eval (
		.period    (rd_period_q),
		.last_fire (rd_last_q),
		.now       (now_q),
		.wait_cur  (wait_q),
		.any       (any_q),
		.res       (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_wait_q <= ptmr_pkg::DEFAULT_WAIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			default_wait_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			chan_valid_q <= '0;
			any_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						case (req.req_type)
							ptmr_pkg::REQ_REGISTER: begin
								if (slot_ok) begin
									chan_valid_q[slot_idx] <= 1'b1;
								end
							end
							ptmr_pkg::REQ_UNREGISTER: begin
								if (slot_ok) begin
									chan_valid_q[slot_idx] <= 1'b0;
								end
							end
							ptmr_pkg::REQ_TICK: begin
								idx_q   <= '0;
								any_q   <= 1'b0;
								state_q <= ST_FETCH;
							end
							default: ;
						endcase
					end
				end
				ST_FETCH: begin
					if (chan_valid_q[idx_q]) begin
						state_q <= ST_EVAL;
					end else if (idx_q == LAST_IDX) begin
						state_q <= ST_REPORT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EVAL: begin
					// a firing channel needs the output register free
					if (!ev.fire || out_free) begin
						any_q <= 1'b1;
						if (idx_q == LAST_IDX) begin
							state_q <= ST_REPORT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_REPORT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_xfer && req.req_type == ptmr_pkg::REQ_TICK) begin
			now_q <= now_t;
		end
		if (state_q == ST_EVAL && (!ev.fire || out_free)) begin
			wait_q <= ev.wait_nxt;
		end
		if (state_q == ST_EVAL && ev.fire && out_free) begin
			out_kind_q <= ptmr_pkg::KIND_FIRE;
			out_slot_q <= idx_wide[ptmr_pkg::SLOT_W-1:0];
			out_wait_q <= '0;
			out_last_q <= 1'b0;
		end else if (state_q == ST_REPORT && out_free) begin
			out_kind_q <= ptmr_pkg::KIND_WAIT;
			out_slot_q <= '0;
			out_wait_q <= any_q ? wait_q : default_wait_q;
			out_last_q <= 1'b1;
		end
	end

	a_report_ends_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPORT && out_free)
		|=> (out_valid_q && out_last_q && state_q == ST_IDLE))
		else $error("wait report not loaded at end of tick");

	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == ptmr_pkg::KIND_FIRE) |-> !out_last_q)
		else $error("fire result flagged as last");

	a_fire_from_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> chan_valid_q[idx_q])
		else $error("evaluating a free channel");

	a_fire_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && ev.fire && !out_free)
		|=> (state_q == ST_EVAL && $stable(idx_q)))
		else $error("scan advanced while fire result stalled");

endmodule

// File: dv/ptmr_checker.sv
// Checker for the periodic multi-channel timer: watches the request, result and
// config channels, predicts fire events and wait reports, compares each transfer.
// Depends on ptmr_pkg and the channel interfaces in ptmr_ifs.sv.
module ptmr_checker (
	input  logic        clk,
	input  logic        arst_n,
	ptmr_req_if         req,
	ptmr_res_if         res,
	ptmr_cfg_if         cfg,
	output int unsigned pending,
	output int unsigned fail_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import ptmr_pkg::*;

	localparam int NUM_SLOTS = 16;
	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] slot;
		wait_t             wait_val;
		logic              last;
	} timer_event_t;

	logic             chan_armed [NUM_SLOTS];
	wait_t            chan_period [NUM_SLOTS];
	logic [NOW_W-1:0] chan_stamp [NUM_SLOTS];
	wait_t            empty_wait;
	timer_event_t     expected_events [$];
	int unsigned      result_no;

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	task automatic add_expected(input timer_event_t ev);
		expected_events = {expected_events, ev};
	endtask

	// scan in slot order; the wait starts at the least period and drops to
	// the remaining time of each channel that did not fire
	task automatic predict_tick(input logic [NOW_W-1:0] now);
		logic             any_armed;
		wait_t            next_wait;
		logic [NOW_W-1:0] elapsed;
		any_armed = 1'b0;
		next_wait = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (chan_armed[i] && (!any_armed || chan_period[i] < next_wait)) begin
				next_wait = chan_period[i];
				any_armed = 1'b1;
			end
		end
		if (!any_armed) begin
			add_expected('{KIND_WAIT, '0, empty_wait, 1'b1});
			return;
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!chan_armed[i])
				continue;
			elapsed = now - chan_stamp[i];
			if (elapsed >= NOW_W'(chan_period[i])) begin
				chan_stamp[i] = now;
				add_expected('{KIND_FIRE, SLOT_W'(i), '0, 1'b0});
			end else if (chan_period[i] - elapsed[WAIT_W-1:0] < next_wait) begin
				next_wait = chan_period[i] - elapsed[WAIT_W-1:0];
			end
		end
		add_expected('{KIND_WAIT, '0, next_wait, 1'b1});
	endtask

	task automatic take_request();
		case (req.req_type)
		REQ_REGISTER: begin
			if (!chan_armed[req.slot]) begin
				chan_armed[req.slot]  = 1'b1;
				chan_period[req.slot] = req.period;
				chan_stamp[req.slot]  = req.now;
			end
		end
		REQ_UNREGISTER: chan_armed[req.slot] = 1'b0;
		REQ_TICK: predict_tick(req.now);
		default: ;
		endcase
	endtask

	task automatic check_result();
		timer_event_t exp_ev;
		result_no++;
		if (expected_events.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with nothing expected", result_no));
			return;
		end
		exp_ev = expected_events.pop_front();
		if (res.kind !== exp_ev.kind)
			report_mismatch($sformatf("result %0d kind: expected %0d, got %0d",
				result_no, exp_ev.kind, res.kind));
		if (res.fired_slot !== exp_ev.slot)
			report_mismatch($sformatf("result %0d fired_slot: expected %0d, got %0d",
				result_no, exp_ev.slot, res.fired_slot));
		if (res.next_wait !== exp_ev.wait_val)
			report_mismatch($sformatf("result %0d next_wait: expected %0h, got %0h",
				result_no, exp_ev.wait_val, res.next_wait));
		if (res.last !== exp_ev.last)
			report_mismatch($sformatf("result %0d last: expected %0d, got %0d",
				result_no, exp_ev.last, res.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				chan_armed[i]  = 1'b0;
				chan_period[i] = '0;
				chan_stamp[i]  = '0;
			end
			empty_wait = DEFAULT_WAIT_RST;
			expected_events.delete();
			result_no  = 0;
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				empty_wait = cfg.data;
			// results are checked before this edge's request is predicted
			if (res.valid && res.ready)
				check_result();
			if (req.valid && req.ready)
				take_request();
			pending = expected_events.size();
		end
	end

endmodule

// File: dv/tb.sv
// Top-level testbench for periodic_multi_channel_timer: clock, reset, request,
// config and result-ready stimulus, watchdog and verdict.
// Depends on ptmr_pkg, ptmr_ifs.sv, ptmr_checker and the RTL top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ptmr_pkg::*;

	localparam int         HOLD_OFF_CYCLES = 300;
	localparam int         QUIET_LIMIT     = 3000;
	localparam int         TARGET_ITEMS    = 410;
	localparam logic [1:0] REQ_UNUSED      = 2'd3;

	typedef struct {
		logic [1:0]        op;
		logic [SLOT_W-1:0] slot;
		wait_t             period;
		logic [NOW_W-1:0]  now;
	} timer_req_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             req_gaps = 1'b1;
	logic             res_gaps = 1'b1;
	logic             hold_res = 1'b0;
	logic [NOW_W-1:0] sim_now = '0;
	int unsigned      items_done = 0;
	int unsigned      quiet_cycles = 0;
	int unsigned      pending;
	int unsigned      fail_count;

	ptmr_req_if req_ch ();
	ptmr_res_if res_ch ();
	ptmr_cfg_if cfg_ch ();

	periodic_multi_channel_timer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	ptmr_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: random backpressure, or a long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_res) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_res = 1'b0;
			end
			res_ch.ready <= !(res_gaps && $urandom_range(99) < 37);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic timer_req_t req_item(input logic [1:0] op, input int unsigned slot,
			input wait_t period, input logic [NOW_W-1:0] now);
		timer_req_t item;
		item.op     = op;
		item.slot   = SLOT_W'(slot);
		item.period = period;
		item.now    = now;
		return item;
	endfunction

	task automatic send_req(input timer_req_t item);
		if (req_gaps)
			while ($urandom_range(99) < 37) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= item.op;
		req_ch.slot     <= item.slot;
		req_ch.period   <= item.period;
		req_ch.now      <= item.now;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		items_done++;
	endtask

	// stop offering, wait out every expected result, then let the block settle
	task automatic drain(input int unsigned settle);
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_default_wait(input wait_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly small periods against a slowly advancing clock, so channels
	// alternate between firing and waiting; some jumps, wraps and rewinds
	task automatic random_request(output timer_req_t item);
		int unsigned pick;
		wait_t       period;
		pick = $urandom_range(99);
		if (pick < 70)
			sim_now += $urandom_range(800);
		else if (pick < 85)
			sim_now += $urandom_range(5000);
		else if (pick < 92)
			sim_now -= $urandom_range(400);
		else
			sim_now = NOW_W'({$urandom, $urandom});
		pick = $urandom_range(19);
		if (pick == 0)
			period = '0;
		else if (pick < 4)
			period = $urandom;
		else
			period = $urandom_range(2000, 1);
		pick = $urandom_range(99);
		if (pick < 32)
			item = req_item(REQ_REGISTER, $urandom_range(15), period, sim_now);
		else if (pick < 47)
			item = req_item(REQ_UNREGISTER, $urandom_range(15), period, NOW_W'({$urandom, $urandom}));
		else if (pick < 96)
			item = req_item(REQ_TICK, $urandom_range(15), period, sim_now);
		else
			item = req_item(REQ_UNUSED, $urandom_range(15), $urandom, NOW_W'({$urandom, $urandom}));
	endtask

	task automatic run_random(input int unsigned upto);
		timer_req_t item;
		while (items_done < upto) begin
			random_request(item);
			send_req(item);
		end
	endtask

	initial begin
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_REGISTER;
		req_ch.slot     <= '0;
		req_ch.period   <= '0;
		req_ch.now      <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.data     <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, field extremes, ignored requests,
		// zero period, exact expiry and time running backwards
		send_req(req_item(REQ_TICK, 0, '0, '0));
		send_req(req_item(REQ_REGISTER, 0, '0, '0));
		send_req(req_item(REQ_REGISTER, 15, '1, '1));
		send_req(req_item(REQ_REGISTER, 0, 32'd5, 48'd123));
		send_req(req_item(REQ_TICK, 0, '0, '0));
		send_req(req_item(REQ_TICK, 0, '0, '1));
		send_req(req_item(REQ_UNUSED, 15, '1, '1));
		send_req(req_item(REQ_UNREGISTER, 7, '0, '0));
		send_req(req_item(REQ_UNREGISTER, 0, '0, '0));
		send_req(req_item(REQ_REGISTER, 7, 32'd100, 48'd1000));
		send_req(req_item(REQ_TICK, 0, '0, 48'd1050));
		send_req(req_item(REQ_TICK, 0, '0, 48'd1100));
		send_req(req_item(REQ_TICK, 0, '0, 48'd900));
		send_req(req_item(REQ_UNREGISTER, 15, '0, '0));
		send_req(req_item(REQ_UNREGISTER, 7, '0, '0));
		send_req(req_item(REQ_TICK, 0, '0, 48'd5));
		drain(8);
		write_default_wait('0);
		send_req(req_item(REQ_TICK, 0, '0, 48'd6));
		drain(8);
		write_default_wait('1);
		send_req(req_item(REQ_TICK, 0, '0, 48'd7));
		drain(8);
		sim_now = 48'd2000;

		write_default_wait($urandom);
		run_random(120);
		drain(8);

		// every channel at zero period: each tick yields the full 17 transfers
		// while the result side holds off and the request side keeps offering
		write_default_wait(DEFAULT_WAIT_RST);
		for (int s = 0; s < 16; s++)
			send_req(req_item(REQ_UNREGISTER, s, $urandom, NOW_W'({$urandom, $urandom})));
		for (int s = 0; s < 16; s++)
			send_req(req_item(REQ_REGISTER, s, '0, sim_now));
		hold_res = 1'b1;
		repeat (8) begin
			sim_now += 7;
			send_req(req_item(REQ_TICK, 0, '0, sim_now));
		end
		drain(8);

		// back-to-back stretch with no idling on either side
		req_gaps = 1'b0;
		res_gaps = 1'b0;
		write_default_wait(32'd1);
		run_random(270);
		drain(8);
		req_gaps = 1'b1;
		res_gaps = 1'b1;

		write_default_wait($urandom);
		run_random(340);
		drain(8);

		write_default_wait($urandom);
		run_random(TARGET_ITEMS);
		drain(40);

		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
